[design/tpgs_pkg.sv]
`default_nettype none
package tpgs_pkg;

	localparam int unsigned MAX_DOCS  = 64;
	localparam int unsigned TOPICS1   = 16;
	localparam int unsigned TOPICS2   = 16;
	localparam int unsigned VOCAB1    = 256;
	localparam int unsigned VOCAB2    = 256;
	localparam int unsigned MAX_LEVEL = 8;
	localparam int unsigned SLOTS     = 2 * MAX_LEVEL;

	localparam int unsigned DOC_DEPTH  = MAX_DOCS * TOPICS1 * TOPICS2;
	localparam int unsigned W1_DEPTH   = VOCAB1 * TOPICS1;
	localparam int unsigned W2_DEPTH   = VOCAB2 * TOPICS2;
	localparam int unsigned PATH_DEPTH = MAX_DOCS * SLOTS;
	localparam int unsigned WBUF_DEPTH = MAX_LEVEL * MAX_LEVEL;

	localparam int unsigned CNT_W   = 16;
	localparam int unsigned TOT_W   = 24;
	localparam int unsigned TOPIC_W = 4;
	localparam int unsigned WGT_W   = 48;
	localparam int unsigned QUO_W   = 17;
	localparam int unsigned MA_W    = 34;
	localparam int unsigned MB_W    = 32;
	localparam int unsigned MP_W    = MA_W + MB_W;

	localparam logic [QUO_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [2:0] {
		CMD_DOC_WR   = 3'd0,
		CMD_WORD1_WR = 3'd1,
		CMD_WORD2_WR = 3'd2,
		CMD_PATH_WR  = 3'd3,
		CMD_DRAW     = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ALPHA_DOC   = 3'd0,
		REG_ALPHA_WORD1 = 3'd1,
		REG_ALPHA_WORD2 = 3'd2,
		REG_LEVEL1      = 3'd3,
		REG_LEVEL2      = 3'd4,
		REG_VOCAB1      = 3'd5,
		REG_VOCAB2      = 3'd6
	} reg_idx_t;

	function automatic logic [3:0] level_of(input logic [3:0] r);
		logic [3:0] l;
		if (r == 4'd0) begin
			l = 4'd1;
		end else if (r > 4'(MAX_LEVEL)) begin
			l = 4'(MAX_LEVEL);
		end else begin
			l = r;
		end
		return l;
	endfunction

endpackage
`default_nettype wire

[design/tpgs_ram.sv]
`default_nettype none
module tpgs_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[design/tpgs_div.sv]
`default_nettype none
module tpgs_div import tpgs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WGT_W-1:0] num,
	input  wire logic [WGT_W-1:0] den,
	output logic                  done,
	output logic      [QUO_W-1:0] quo
);

	logic [WGT_W-1:0] rem_q;
	logic [WGT_W-1:0] den_q;
	logic [4:0]       cnt_q;
	logic             run_q;
	logic [WGT_W:0]   r2;
	logic             ge;

	assign r2 = {rem_q, 1'b0};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			quo   <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				den_q <= den;
				if (den == '0) begin
					quo  <= '0;
					done <= 1'b1;
				end else if (num >= den) begin
					quo  <= ONE_Q16;
					done <= 1'b1;
				end else begin
					rem_q <= num;
					quo   <= '0;
					cnt_q <= 5'd16;
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				rem_q <= ge ? WGT_W'(r2 - {1'b0, den_q}) : WGT_W'(r2);
				quo   <= {quo[QUO_W-2:0], ge};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

[design/tpgs_mul.sv]
`default_nettype none
module tpgs_mul import tpgs_pkg::*; (
	input  wire logic            clk,
	input  wire logic [MA_W-1:0] a,
	input  wire logic [MB_W-1:0] b,
	output logic      [MP_W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= MP_W'(a) * MP_W'(b);
	end

endmodule
`default_nettype wire

[design/topic_pair_gibbs_sampler_core.sv]
// a write holds the block through S_EXEC, and S_WUPD for word writes; a draw holds the block
// until the result is valid, paced by the shared 16-step divider run twice per pair and once at
// the end when the weight sum is not zero, plus S_SRD and S_SCMP per pair in the cumulative search
// throughput: one item at a time; after a draw, the next item is taken after the result is taken
// reset: asynchronous, active low; a clearing pass then zeroes the count memories,
// and no item is taken until it ends
`default_nettype none
module topic_pair_gibbs_sampler_core import tpgs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [87:0] s_tdata,  // doc, word1, word2, topic1, topic2, path_slot, value, uniform
	input  wire logic [2:0]  s_tuser,  // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // new_topic1, new_topic2, probability
	output logic      [0:0]  m_tuser,  // zero_weight
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_WUPD,
		S_V1, S_V2, S_V3, S_P1, S_P2, S_RD, S_CNT, S_DIV1, S_DIV2, S_M1, S_M2, S_M3,
		S_T1, S_T2, S_T3, S_SRD, S_SCMP, S_F1, S_F2, S_F3, S_FDIV, S_OUT
	} state_t;

	state_t state_q;

	logic [23:0] alpha_d_q, alpha_1_q, alpha_2_q;
	logic [3:0]  lvl1_q, lvl2_q;
	logic [8:0]  voc1_q, voc2_q;

	logic [2:0]  cmd_q;
	logic [5:0]  doc_q;
	logic [7:0]  w1_q, w2_q;
	logic [3:0]  t1_q, t2_q, slot_q;
	logic [15:0] val_q;
	logic [31:0] u_q;

	logic [13:0] clr_q;
	logic [TOT_W-1:0] tot1_q [TOPICS1];
	logic [TOT_W-1:0] tot2_q [TOPICS2];

	logic [2:0] i_q, k_q;
	logic [5:0] idx_q;
	logic [3:0] p1_q, p2_q, nt1_q, nt2_q;
	logic [32:0] d1c_q, d2c_q;
	logic [MA_W-1:0] a_q;
	logic [WGT_W-1:0] n2_q, d2_q, sum_q, thr_q, cum_q, pickw_q;
	logic [QUO_W-1:0] r1_q, r2_q, prob_q;
	logic [31:0] lo_q;
	logic zero_q;

	logic [3:0] l1, l2;
	logic last_i, last_k;
	assign l1 = level_of(lvl1_q);
	assign l2 = level_of(lvl2_q);
	assign last_i = ({1'b0, i_q} == l1 - 4'd1);
	assign last_k = ({1'b0, k_q} == l2 - 4'd1);

	// memories
	logic        clearing;
	logic        doc_we, w1_we, w2_we, path_we, wb_we;
	logic [13:0] doc_waddr, doc_raddr;
	logic [11:0] w1_waddr, w1_raddr, w2_waddr, w2_raddr;
	logic [9:0]  path_waddr, path_raddr;
	logic [15:0] doc_rd, w1_rd, w2_rd;
	logic [3:0]  path_rd;
	logic [WGT_W-1:0] wb_rd, w_new;

	assign clearing   = state_q == S_CLEAR;
	assign doc_we     = clearing || (state_q == S_EXEC && cmd_q == CMD_DOC_WR);
	assign doc_waddr  = clearing ? clr_q : {doc_q, t2_q, t1_q};
	assign doc_raddr  = {doc_q, path_rd, p1_q};
	assign w1_we      = clearing || (state_q == S_WUPD && cmd_q == CMD_WORD1_WR);
	assign w1_waddr   = clearing ? clr_q[11:0] : {w1_q, t1_q};
	assign w1_raddr   = (state_q == S_RD) ? {w1_q, p1_q} : {w1_q, t1_q};
	assign w2_we      = clearing || (state_q == S_WUPD && cmd_q == CMD_WORD2_WR);
	assign w2_waddr   = clearing ? clr_q[11:0] : {w2_q, t2_q};
	assign w2_raddr   = (state_q == S_RD) ? {w2_q, path_rd} : {w2_q, t2_q};
	assign path_we    = state_q == S_EXEC && cmd_q == CMD_PATH_WR;
	assign path_waddr = {doc_q, slot_q};
	assign path_raddr = (state_q == S_P1 || state_q == S_F1) ? {doc_q, 1'b0, i_q}
		: {doc_q, l1 + {1'b0, k_q}};
	assign wb_we      = state_q == S_M3;

	tpgs_ram #(.WIDTH(CNT_W), .DEPTH(DOC_DEPTH)) u_doc (
		.clk, .we(doc_we), .waddr(doc_waddr), .wdata(clearing ? 16'd0 : val_q),
		.raddr(doc_raddr), .rdata(doc_rd));
	tpgs_ram #(.WIDTH(CNT_W), .DEPTH(W1_DEPTH)) u_w1 (
		.clk, .we(w1_we), .waddr(w1_waddr), .wdata(clearing ? 16'd0 : val_q),
		.raddr(w1_raddr), .rdata(w1_rd));
	tpgs_ram #(.WIDTH(CNT_W), .DEPTH(W2_DEPTH)) u_w2 (
		.clk, .we(w2_we), .waddr(w2_waddr), .wdata(clearing ? 16'd0 : val_q),
		.raddr(w2_raddr), .rdata(w2_rd));
	tpgs_ram #(.WIDTH(TOPIC_W), .DEPTH(PATH_DEPTH)) u_path (
		.clk, .we(path_we), .waddr(path_waddr), .wdata(val_q[3:0]),
		.raddr(path_raddr), .rdata(path_rd));
	tpgs_ram #(.WIDTH(WGT_W), .DEPTH(WBUF_DEPTH)) u_wbuf (
		.clk, .we(wb_we), .waddr(idx_q), .wdata(w_new),
		.raddr(idx_q), .rdata(wb_rd));

	// shared multiplier
	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [MP_W-1:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_V1: begin
				mul_a = MA_W'(alpha_1_q);
				mul_b = MB_W'(voc1_q);
			end
			S_V2: begin
				mul_a = MA_W'(alpha_2_q);
				mul_b = MB_W'(voc2_q);
			end
			S_M1: begin
				mul_a = a_q;
				mul_b = MB_W'(r1_q);
			end
			S_M2: begin
				mul_a = prod[MA_W+15:16];
				mul_b = MB_W'(r2_q);
			end
			S_T1: begin
				mul_a = MA_W'(u_q);
				mul_b = sum_q[31:0];
			end
			S_T2: begin
				mul_a = MA_W'(u_q);
				mul_b = MB_W'(sum_q[WGT_W-1:32]);
			end
			default: ;
		endcase
	end

	tpgs_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p(prod));

	assign w_new = WGT_W'(prod[MP_W-1:16]);

	// shared divider
	logic             s1, s2;
	logic [33:0]      a_v, n1_v, n2_v;
	logic [WGT_W-1:0] d1_v, d2_v;
	logic             div_start, div_done;
	logic [WGT_W-1:0] div_num, div_den;
	logic [QUO_W-1:0] div_quo;

	assign s1   = p1_q == t1_q;
	assign s2   = p2_q == t2_q;
	assign a_v  = {2'b0, doc_rd, 16'd0} + 34'(alpha_d_q);
	assign n1_v = {2'b0, w1_rd, 16'd0} + 34'(alpha_1_q);
	assign n2_v = {2'b0, w2_rd, 16'd0} + 34'(alpha_2_q);
	assign d1_v = WGT_W'({tot1_q[p1_q], 16'd0}) + WGT_W'(d1c_q);
	assign d2_v = WGT_W'({tot2_q[p2_q], 16'd0}) + WGT_W'(d2c_q);

	function automatic logic [33:0] own_sub(input logic [33:0] v, input logic own);
		logic [33:0] r;
		if (!own) begin
			r = v;
		end else if (v > 34'h10000) begin
			r = v - 34'h10000;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			S_CNT: begin
				div_start = 1'b1;
				div_num   = WGT_W'(own_sub(n1_v, s1));
				div_den   = d1_v;
			end
			S_DIV1: begin
				div_start = div_done;
				div_num   = n2_q;
				div_den   = d2_q;
			end
			S_F3: begin
				div_start = !zero_q;
				div_num   = pickw_q;
				div_den   = sum_q;
			end
			default: ;
		endcase
	end

	tpgs_div u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo));

	logic [WGT_W-1:0] cum_nx;
	assign cum_nx = cum_q + wb_rd;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = state_q == S_OUT;
	assign m_tdata  = {7'd0, prob_q, nt2_q, nt1_q};
	assign m_tuser  = zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			alpha_d_q <= 24'd65536;
			alpha_1_q <= 24'd65536;
			alpha_2_q <= 24'd65536;
			lvl1_q    <= 4'd1;
			lvl2_q    <= 4'd1;
			voc1_q    <= 9'd256;
			voc2_q    <= 9'd256;
			for (int t = 0; t < TOPICS1; t++) tot1_q[t] <= '0;
			for (int t = 0; t < TOPICS2; t++) tot2_q[t] <= '0;
			cmd_q <= '0;
			i_q   <= '0;
			k_q   <= '0;
			idx_q <= '0;
			zero_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ALPHA_DOC:   alpha_d_q <= cfg_data;
					REG_ALPHA_WORD1: alpha_1_q <= cfg_data;
					REG_ALPHA_WORD2: alpha_2_q <= cfg_data;
					REG_LEVEL1:      lvl1_q    <= cfg_data[3:0];
					REG_LEVEL2:      lvl2_q    <= cfg_data[3:0];
					REG_VOCAB1:      voc1_q    <= cfg_data[8:0];
					REG_VOCAB2:      voc2_q    <= cfg_data[8:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 14'd1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q  <= s_tuser;
						doc_q  <= s_tdata[5:0];
						w1_q   <= s_tdata[13:6];
						w2_q   <= s_tdata[21:14];
						t1_q   <= s_tdata[25:22];
						t2_q   <= s_tdata[29:26];
						slot_q <= s_tdata[33:30];
						val_q  <= s_tdata[49:34];
						u_q    <= s_tdata[81:50];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q)
						CMD_WORD1_WR, CMD_WORD2_WR: state_q <= S_WUPD;
						CMD_DRAW: state_q <= S_V1;
						default: state_q <= S_IDLE;
					endcase
				end
				S_WUPD: begin
					if (cmd_q == CMD_WORD1_WR) begin
						tot1_q[t1_q] <= tot1_q[t1_q] - TOT_W'(w1_rd) + TOT_W'(val_q);
					end else begin
						tot2_q[t2_q] <= tot2_q[t2_q] - TOT_W'(w2_rd) + TOT_W'(val_q);
					end
					state_q <= S_IDLE;
				end
				S_V1: begin
					i_q   <= '0;
					k_q   <= '0;
					idx_q <= '0;
					sum_q <= '0;
					state_q <= S_V2;
				end
				S_V2: begin
					d1c_q   <= prod[32:0];
					state_q <= S_V3;
				end
				S_V3: begin
					d2c_q   <= prod[32:0];
					state_q <= S_P1;
				end
				S_P1: state_q <= S_P2;
				S_P2: begin
					p1_q    <= path_rd;
					state_q <= S_RD;
				end
				S_RD: begin
					p2_q    <= path_rd;
					state_q <= S_CNT;
				end
				S_CNT: begin
					a_q     <= own_sub(a_v, s1 & s2);
					n2_q    <= WGT_W'(own_sub(n2_v, s2));
					d2_q    <= d2_v;
					state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (div_done) begin
						r1_q    <= div_quo;
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						r2_q    <= div_quo;
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: begin
					sum_q <= sum_q + w_new;
					idx_q <= idx_q + 6'd1;
					if (last_i) begin
						i_q <= '0;
						if (last_k) begin
							k_q     <= '0;
							state_q <= S_T1;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= S_P1;
						end
					end else begin
						i_q     <= i_q + 3'd1;
						state_q <= S_P1;
					end
				end
				S_T1: begin
					idx_q <= '0;
					cum_q <= '0;
					if (sum_q == '0) begin
						zero_q  <= 1'b1;
						state_q <= S_F1;
					end else begin
						zero_q  <= 1'b0;
						state_q <= S_T2;
					end
				end
				S_T2: begin
					lo_q    <= prod[63:32];
					state_q <= S_T3;
				end
				S_T3: begin
					thr_q   <= prod[WGT_W-1:0] + WGT_W'(lo_q);
					state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					cum_q <= cum_nx;
					if (cum_nx > thr_q || (last_i && last_k)) begin
						pickw_q <= wb_rd;
						state_q <= S_F1;
					end else begin
						idx_q <= idx_q + 6'd1;
						if (last_i) begin
							i_q <= '0;
							k_q <= k_q + 3'd1;
						end else begin
							i_q <= i_q + 3'd1;
						end
						state_q <= S_SRD;
					end
				end
				S_F1: state_q <= S_F2;
				S_F2: begin
					nt1_q   <= path_rd;
					state_q <= S_F3;
				end
				S_F3: begin
					nt2_q <= path_rd;
					if (zero_q) begin
						prob_q  <= ONE_Q16;
						state_q <= S_OUT;
					end else begin
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (div_done) begin
						prob_q  <= div_quo;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	a_ready_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> s_tready)
		else $error("not ready after result taken");

	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24:8] <= ONE_Q16))
		else $error("probability above one");

	a_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[24:8] == ONE_Q16))
		else $error("zero weight without probability one");

endmodule
`default_nettype wire
